[sv/rbs_pkg.sv]
package rbs_pkg;

	localparam int COORD_W = 32;
	localparam int HALF_W  = 31;
	localparam int FRAC_W  = 17;

	localparam logic [HALF_W-1:0] HALF_RESET = 31'd32768;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [HALF_W-1:0]         half_t;

	typedef enum logic [1:0] {
		CFG_HALF_X = 2'd0,
		CFG_HALF_Y = 2'd1,
		CFG_HALF_Z = 2'd2
	} cfg_idx_t;

	// per-axis side info that rides alongside the dividers
	typedef struct packed {
		logic   rej;
		coord_t s;
		coord_t e;
	} lane_side_t;

endpackage

[sv/ray_box_slab_intersect.sv]
// Segment versus centered box, slab test. One segment word is taken per
// cycle while in_stall is low; each word passes FRAC_BITS+5 register
// stages: a setup stage, FRAC_BITS+1 stages of the per-axis dividers (one
// quotient bit each), a merge stage, a multiply stage and the output
// register. Three lanes (x, y, z) each run an entry and an exit divider.
// Each stage holds its word only while the stage after it is full and
// stalled, so bubbles close up and input is taken while a result waits.
// Half extents are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while idle, which the block does not enforce;
// index values past half_z are ignored.
module ray_box_slab_intersect import rbs_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [HALF_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  coord_t            start_x,
	input  coord_t            start_y,
	input  coord_t            start_z,
	input  coord_t            end_x,
	input  coord_t            end_y,
	input  coord_t            end_z,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              hit,
	output logic [FRAC_W-1:0] hit_fraction,
	output coord_t            point_x,
	output coord_t            point_y,
	output coord_t            point_z
);

	localparam int NST = FRAC_BITS + 5;

	// box registers
	half_t half_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) half_q[i] <= HALF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HALF_X: half_q[0] <= cfg_wdata;
				CFG_HALF_Y: half_q[1] <= cfg_wdata;
				CFG_HALF_Z: half_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage valids and load enables; a stage loads when empty or draining
	logic [NST-1:0] v_q;
	logic [NST-1:0] en;

	assign en[NST-1] = !v_q[NST-1] || !out_stall;
	for (genvar k = 0; k < NST-1; k++) begin : g_en
		assign en[k] = !v_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= in_valid;
			for (int k = 1; k < NST; k++)
				if (en[k]) v_q[k] <= v_q[k-1];
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = v_q[NST-1];

	// lanes
	coord_t             ps [3], pe [3], pt [3];
	lane_side_t         side [3];
	logic [FRAC_BITS:0] st [3], et [3];

	assign ps[0] = start_x;
	assign ps[1] = start_y;
	assign ps[2] = start_z;
	assign pe[0] = end_x;
	assign pe[1] = end_y;
	assign pe[2] = end_z;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		rbs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk   (clk),
			.en    (en[FRAC_BITS+1:0]),
			.pos_s (ps[i]),
			.pos_e (pe[i]),
			.half  (half_q[i]),
			.side  (side[i]),
			.st    (st[i]),
			.et    (et[i])
		);
	end

	rbs_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
		.clk  (clk),
		.en   (en[NST-1:FRAC_BITS+2]),
		.side (side),
		.st   (st),
		.et   (et),
		.hit  (hit),
		.frac (hit_fraction),
		.pt   (pt)
	);

	assign point_x = pt[0];
	assign point_y = pt[1];
	assign point_z = pt[2];

endmodule

[sv/rbs_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// q = min(floor(num * 2^FRAC_BITS / den), 2^FRAC_BITS); den must be nonzero.
module rbs_div import rbs_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic [FRAC_BITS:0]   en,
	input  logic [31:0]          num,
	input  logic [31:0]          den,
	output logic [FRAC_BITS:0]   q
);

	logic                 sat_s [FRAC_BITS+1];
	logic [31:0]          r_s   [FRAC_BITS+1];
	logic [31:0]          d_s   [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] qb_s  [FRAC_BITS+1];

	// num >= den means the quotient is at least one: saturate
	always_ff @(posedge clk) begin
		if (en[0]) begin
			sat_s[0] <= (num >= den);
			r_s[0]   <= num;
			d_s[0]   <= den;
			qb_s[0]  <= '0;
		end
	end

	for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_bit
		logic [32:0] r2;
		logic        ge;
		assign r2 = {r_s[k-1], 1'b0};
		assign ge = (r2 >= {1'b0, d_s[k-1]});
		always_ff @(posedge clk) begin
			if (en[k]) begin
				sat_s[k] <= sat_s[k-1];
				r_s[k]   <= ge ? 32'(r2 - {1'b0, d_s[k-1]}) : r2[31:0];
				d_s[k]   <= d_s[k-1];
				qb_s[k]  <= {qb_s[k-1][FRAC_BITS-2:0], ge};
			end
		end
	end

	assign q = sat_s[FRAC_BITS] ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, qb_s[FRAC_BITS]};

endmodule

[sv/rbs_lane.sv]
// One axis: slab setup, entry and exit dividers, side info delay.
module rbs_lane import rbs_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic [FRAC_BITS+1:0] en,
	input  coord_t               pos_s,
	input  coord_t               pos_e,
	input  half_t                half,
	output lane_side_t           side,
	output logic [FRAC_BITS:0]   st,
	output logic [FRAC_BITS:0]   et
);

	logic signed [33:0] s34, e34, hi, lo;
	logic               rej;
	logic [31:0]        st_n, st_d, et_n, et_d;

	assign s34 = {{2{pos_s[31]}}, pos_s};
	assign e34 = {{2{pos_e[31]}}, pos_e};
	assign hi  = {3'b000, half};
	assign lo  = -hi;

	// unused fractions fed as 0/1 (gives 0) and 1/1 (saturates to one)
	always_comb begin
		st_n = 32'd0;
		st_d = 32'd1;
		et_n = 32'd1;
		et_d = 32'd1;
		if (s34 < e34) begin
			rej = (s34 > hi) || (e34 < lo);
			if (s34 < lo) begin
				st_n = 32'(lo - s34);
				st_d = 32'(e34 - s34);
			end
			if (e34 > hi) begin
				et_n = 32'(hi - s34);
				et_d = 32'(e34 - s34);
			end
		end else begin
			rej = (e34 > hi) || (s34 < lo);
			if (s34 > hi && s34 != e34) begin
				st_n = 32'(s34 - hi);
				st_d = 32'(s34 - e34);
			end
			if (e34 < lo && s34 != e34) begin
				et_n = 32'(s34 - lo);
				et_d = 32'(s34 - e34);
			end
		end
	end

	logic [31:0] st_n_s0, st_d_s0, et_n_s0, et_d_s0;
	lane_side_t  side_s [FRAC_BITS+2];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			st_n_s0   <= st_n;
			st_d_s0   <= st_d;
			et_n_s0   <= et_n;
			et_d_s0   <= et_d;
			side_s[0] <= '{rej: rej, s: pos_s, e: pos_e};
		end
	end

	for (genvar k = 1; k <= FRAC_BITS+1; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en[k]) side_s[k] <= side_s[k-1];
		end
	end

	assign side = side_s[FRAC_BITS+1];

	rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_st (
		.clk (clk),
		.en  (en[FRAC_BITS+1:1]),
		.num (st_n_s0),
		.den (st_d_s0),
		.q   (st)
	);

	rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_et (
		.clk (clk),
		.en  (en[FRAC_BITS+1:1]),
		.num (et_n_s0),
		.den (et_d_s0),
		.q   (et)
	);

endmodule

[sv/rbs_merge.sv]
// Combine lanes, then interpolate the hit point and register the result.
module rbs_merge import rbs_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic [2:0]         en,
	input  lane_side_t         side [3],
	input  logic [FRAC_BITS:0] st   [3],
	input  logic [FRAC_BITS:0] et   [3],
	output logic               hit,
	output logic [FRAC_W-1:0]  frac,
	output coord_t             pt   [3]
);

	localparam int PW = 33 + FRAC_BITS + 2;

	logic [FRAC_BITS:0] fst, fet, m01, n01;
	logic               any_rej;

	assign m01     = (st[0] > st[1]) ? st[0] : st[1];
	assign fst     = (m01 > st[2]) ? m01 : st[2];
	assign n01     = (et[0] < et[1]) ? et[0] : et[1];
	assign fet     = (n01 < et[2]) ? n01 : et[2];
	assign any_rej = side[0].rej || side[1].rej || side[2].rej;

	logic               hit_s1, hit_s2;
	logic [FRAC_BITS:0] f_s1, f_s2;
	coord_t             s_s1 [3], e_s1 [3], s_s2 [3];
	logic signed [PW-1:0] prod_s2 [3];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			hit_s1 <= !any_rej && (fet >= fst);
			f_s1   <= fst;
			for (int i = 0; i < 3; i++) begin
				s_s1[i] <= side[i].s;
				e_s1[i] <= side[i].e;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hit_s2 <= hit_s1;
			f_s2   <= f_s1;
			for (int i = 0; i < 3; i++) begin
				s_s2[i]    <= s_s1[i];
				prod_s2[i] <= PW'(($signed({e_s1[i][31], e_s1[i]})
					- $signed({s_s1[i][31], s_s1[i]})) * $signed({1'b0, f_s1}));
			end
		end
	end

	// round to nearest, ties up: add half then floor shift
	logic signed [PW-1:0] rnd [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			rnd[i] = (prod_s2[i] + PW'(1 << (FRAC_BITS-1))) >>> FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			hit  <= hit_s2;
			frac <= hit_s2 ? FRAC_W'(f_s2) : '0;
			for (int i = 0; i < 3; i++)
				pt[i] <= hit_s2 ? coord_t'(s_s2[i] + rnd[i][31:0]) : '0;
		end
	end

endmodule

[sv/rbs_chk.sv]
module rbs_chk import rbs_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_we,
	input logic [1:0]        cfg_index,
	input logic [HALF_W-1:0] cfg_wdata,
	input logic              in_valid,
	input logic              in_stall,
	input coord_t            start_x,
	input coord_t            start_y,
	input coord_t            start_z,
	input coord_t            end_x,
	input coord_t            end_y,
	input coord_t            end_z,
	input logic              out_valid,
	input logic              out_stall,
	input logic              hit,
	input logic [FRAC_W-1:0] hit_fraction,
	input coord_t            point_x,
	input coord_t            point_y,
	input coord_t            point_z
);

	// a held result word keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(hit_fraction)
			&& $stable(point_x) && $stable(point_y) && $stable(point_z))
		else $error("result word changed while stalled");

	// input backs up only when the pipe is full behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with room in pipeline");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_fraction == '0 && point_x == '0
			&& point_y == '0 && point_z == '0)
		else $error("miss carries nonzero payload");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> (FRAC_BITS > 16) || (hit_fraction <= FRAC_W'(1 << FRAC_BITS)))
		else $error("hit fraction above one");

endmodule

bind ray_box_slab_intersect rbs_chk #(.FRAC_BITS(FRAC_BITS)) u_rbs_chk (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps

// Testbench for ray_box_slab_intersect.
// Segments go in through the valid/stall input channel. Each accepted word is
// run through a local slab predictor, and the expected result is queued. The
// checker pops the oldest expectation for every result word that leaves the
// block and compares it field by field.
module testbench;
	import rbs_pkg::*;

	localparam int FRAC    = 16;
	localparam longint ONE = 64'd1 << FRAC;
	localparam int LAT     = 40;     // pipeline is FRAC+5 deep; margin on top
	localparam int LIMIT   = 400000; // cycle cap for the whole run

	// index past half_z: the block must ignore it
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic              hit;
		logic [FRAC_W-1:0] frac;
		coord_t            px;
		coord_t            py;
		coord_t            pz;
	} slab_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [HALF_W-1:0] cfg_wdata;
	logic              in_valid;
	logic              in_stall;
	coord_t            start_x, start_y, start_z;
	coord_t            end_x, end_y, end_z;
	logic              out_valid;
	logic              out_stall;
	logic              hit;
	logic [FRAC_W-1:0] hit_fraction;
	coord_t            point_x, point_y, point_z;

	ray_box_slab_intersect u_top (.*);

	// local copy of the box registers
	half_t half_cur [3];

	slab_result_t pending_hits [$];

	int send_idle_pct;
	int recv_idle_pct;
	int mismatches;
	int cycles;

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Cycle cap: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("ray_box_slab_intersect test failed");
			$finish;
		end
	end

	// Receiver stalls at random; one assignment per falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Slab fraction: |num| / |d| in Q1.16, floor, clamped to one.
	function automatic longint slab_frac(longint num, longint d);
		longint an, ad, q;
		an = (num < 0) ? -num : num;
		ad = (d < 0) ? -d : d;
		q  = (an << FRAC) / ad;
		return (q > ONE) ? ONE : q;
	endfunction

	// Expected result of one segment against the current box.
	function automatic slab_result_t slab_predict(coord_t sx, coord_t sy, coord_t sz,
			coord_t ex, coord_t ey, coord_t ez);
		longint s [3];
		longint e [3];
		longint lo, hi, d, st, et, entry, leave, prod, p;
		logic in_box;
		slab_result_t r;
		s[0] = sx; s[1] = sy; s[2] = sz;
		e[0] = ex; e[1] = ey; e[2] = ez;
		entry  = 0;
		leave  = ONE;
		in_box = 1'b1;
		for (int i = 0; i < 3; i++) begin
			hi = longint'(half_cur[i]);
			lo = -hi;
			d  = e[i] - s[i];
			st = 0;
			et = ONE;
			if (s[i] < e[i]) begin
				if (s[i] > hi || e[i] < lo) begin
					in_box = 1'b0;
					break;
				end
				if (s[i] < lo) st = slab_frac(lo - s[i], d);
				if (e[i] > hi) et = slab_frac(hi - s[i], d);
			end else begin
				// falling or degenerate axis; a degenerate one never divides
				if (e[i] > hi || s[i] < lo) begin
					in_box = 1'b0;
					break;
				end
				if (s[i] > hi && d != 0) st = slab_frac(hi - s[i], d);
				if (e[i] < lo && d != 0) et = slab_frac(lo - s[i], d);
			end
			if (st > entry) entry = st;
			if (et < leave) leave = et;
			if (leave < entry) begin
				in_box = 1'b0;
				break;
			end
		end
		r = '{hit: 1'b0, frac: '0, px: '0, py: '0, pz: '0};
		if (in_box) begin
			r.hit  = 1'b1;
			r.frac = entry[FRAC_W-1:0];
			for (int i = 0; i < 3; i++) begin
				// round to nearest, ties up: arithmetic shift floors
				prod = (e[i] - s[i]) * entry;
				p = s[i] + ((prod + (ONE >>> 1)) >>> FRAC);
				case (i)
					0: r.px = p[31:0];
					1: r.py = p[31:0];
					default: r.pz = p[31:0];
				endcase
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		$display("%0t mismatch %s: expected %0h got %0h", $time, what, want, got);
		mismatches++;
	endtask

	// Result checker: compare each accepted word with the oldest expectation.
	always @(posedge clk) begin
		slab_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_hits.size() == 0) begin
				report_mismatch("unexpected word", 0, hit);
			end else begin
				want = pending_hits.pop_front();
				if (hit !== want.hit) report_mismatch("hit", want.hit, hit);
				if (hit_fraction !== want.frac)
					report_mismatch("hit_fraction", want.frac, hit_fraction);
				if (point_x !== want.px) report_mismatch("point_x", want.px, point_x);
				if (point_y !== want.py) report_mismatch("point_y", want.py, point_y);
				if (point_z !== want.pz) report_mismatch("point_z", want.pz, point_z);
			end
		end
	end

	// Send one segment word; called and returning at a falling edge.
	// Valid stays high afterwards so back-to-back words need no drop.
	task automatic send_segment(coord_t sx, coord_t sy, coord_t sz,
			coord_t ex, coord_t ey, coord_t ez);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		start_x = sx; start_y = sy; start_z = sz;
		end_x = ex; end_y = ey; end_z = ez;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		pending_hits.push_back(slab_predict(sx, sy, sz, ex, ey, ez));
		@(negedge clk);
	endtask

	// Wait until the pipe is drained, then write one box register.
	task automatic write_half(logic [1:0] idx, half_t val);
		in_valid = 1'b0;
		while (pending_hits.size() != 0) @(negedge clk);
		repeat (LAT) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_HALF_X: half_cur[0] = val;
			CFG_HALF_Y: half_cur[1] = val;
			CFG_HALF_Z: half_cur[2] = val;
			default: ;
		endcase
	endtask

	task automatic set_box(half_t hx, half_t hy, half_t hz);
		write_half(CFG_HALF_X, hx);
		write_half(CFG_HALF_Y, hy);
		write_half(CFG_HALF_Z, hz);
	endtask

	// Coordinate scaled to the box so hits, touches and misses all occur.
	function automatic coord_t pick_coord(half_t h);
		longint span;
		span = longint'(h) * 3 + 1;
		case ($urandom_range(9))
			0: return coord_t'($urandom);
			1: return coord_t'(h);
			2: return -coord_t'(h);
			3: return '0;
			4: return coord_t'(h) + coord_t'($urandom_range(2)) - 1;
			default: return coord_t'(longint'($urandom) % span);
		endcase
	endfunction

	function automatic half_t pick_half();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return half_t'($urandom);
			3: return half_t'($urandom_range(3));
			default: return half_t'($urandom_range(32'h0008_0000));
		endcase
	endfunction

	// Reset box (0.5 each side): crossings, touches, degenerate axes.
	task automatic test_default_box();
		send_segment(-65536, 0, 0, 65536, 0, 0);         // enters at one quarter
		send_segment(65536, 0, 0, -65536, 0, 0);         // same, reversed
		send_segment(32768, -65536, 0, 32768, 65536, 0); // grazes the x face
		send_segment(0, 0, 0, 0, 0, 0);                  // point inside
		send_segment(65536, 0, 0, 65536, 0, 0);          // point outside
		send_segment(40000, 0, 0, 50000, 10, 10);        // beyond one face
		send_segment(-65536, -65536, 0, 65536, 65536, 0);
		send_segment(-98304, 32768, 0, 0, -65536, 0);    // corner, exit equals entry
		send_segment(-98305, 32768, 0, 1, -65536, 0);    // just past the corner
	endtask

	// Extremes of every input field.
	task automatic test_extreme_coords();
		send_segment(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
		send_segment(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_segment(32'sh7fff_ffff, 0, 0, 32'sh7fff_ffff, 0, 0);
		send_segment(-1, -1, -1, 1, 1, 1);
	endtask

	// Flat box on z, and writes to the unused index.
	task automatic test_flat_box();
		set_box(65536, 65536, 0);
		write_half(CFG_UNUSED, '1);
		send_segment(0, 0, -65536, 0, 0, 65536);   // crosses z = 0
		send_segment(0, 0, 1, 0, 0, 65536);        // stays above
		send_segment(0, 0, 0, 0, 0, 0);
		send_segment(100, 200, 0, -300, 400, 0);   // lies in the plane
	endtask

	// Largest half extents: every coordinate but the most negative lies inside.
	task automatic test_huge_box();
		set_box('1, '1, '1);
		send_segment(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
		send_segment(32'sh8000_0000, 5, 32'sh7fff_ffff, 32'sh8000_0000, 5, -7);
	endtask

	// Random segments; box changes every hundred words.
	task automatic test_random_segments(int count);
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) set_box(pick_half(), pick_half(), pick_half());
			send_segment(pick_coord(half_cur[0]), pick_coord(half_cur[1]),
				pick_coord(half_cur[2]), pick_coord(half_cur[0]),
				pick_coord(half_cur[1]), pick_coord(half_cur[2]));
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_HALF_X;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		start_x = '0; start_y = '0; start_z = '0;
		end_x = '0; end_y = '0; end_z = '0;
		out_stall = 1'b0;
		mismatches = 0;
		cycles = 0;
		for (int i = 0; i < 3; i++) half_cur[i] = HALF_RESET;
		send_idle_pct = 12;
		recv_idle_pct = 77;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_default_box();
		test_extreme_coords();
		test_random_segments(400);

		send_idle_pct = 77;
		recv_idle_pct = 12;
		test_flat_box();
		test_random_segments(400);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_huge_box();
		test_random_segments(400);

		in_valid = 1'b0;
		while (pending_hits.size() != 0) @(negedge clk);
		repeat (LAT) @(negedge clk);
		if (mismatches == 0)
			$display("ray_box_slab_intersect test passed");
		else
			$display("ray_box_slab_intersect test failed");
		$finish;
	end

endmodule
